// File: src/sdbp_pkg.sv
package sdbp_pkg;

    localparam int SYMBOLS   = 256;
    localparam int PROB_BITS = 16;
    localparam int IDX_W     = $clog2(SYMBOLS);
    localparam int SUM_W     = PROB_BITS + IDX_W;
    localparam int OUT_BITS  = 12;
    localparam int QUO_W     = OUT_BITS + 1;
    localparam int NUM_W     = SUM_W + QUO_W + 1;
    localparam int STEP_W    = $clog2(QUO_W);

    localparam logic [PROB_BITS-1:0] PROB_INIT = PROB_BITS'((1 << PROB_BITS) / SYMBOLS);
    localparam logic [IDX_W-1:0]     TOP_INIT  = IDX_W'(SYMBOLS - 1);
    localparam logic [OUT_BITS-1:0]  P_HALF    = OUT_BITS'(1 << (OUT_BITS - 1));
    localparam logic [OUT_BITS-1:0]  P_MIN     = OUT_BITS'(1);
    localparam logic [OUT_BITS-1:0]  P_MAX     = OUT_BITS'((1 << OUT_BITS) - 1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

endpackage

// File: src/symbol_dist_to_bit_prediction.sv
// Bit prediction from a stored symbol distribution.
// One command channel: a transaction is taken at a rising edge where start is
// high and busy is low. A load transaction (cmd low) writes one table entry
// and returns nothing; busy stays low.
// A bit-step transaction (cmd high) narrows the symbol range (bit position 0
// reopens it in full), then reads every entry of the new range from the table
// memory, one address per cycle, accumulating the range total, the upper-half
// sum and the largest entry. A restoring divider then forms the bit
// probability, one quotient bit per cycle for 13 quotient bits; a range whose
// total is zero skips the divider and answers with a probability of one half.
// busy is high from the cycle after a bit step is taken until its result.
// The result appears on bit_prob and likely_symbol for exactly one cycle with
// result_valid high; the receiver cannot stall it.
// Reset marks every table entry as holding one in 256 and opens the full range.
module symbol_dist_to_bit_prediction (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [7:0]                     entry_index,
    input  logic [15:0]                    entry_prob,
    input  logic [2:0]                     bit_position,
    input  logic                           prev_bit,
    output logic                           result_valid,
    output logic [sdbp_pkg::OUT_BITS-1:0]  bit_prob,
    output logic [7:0]                     likely_symbol
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PREP,
        ST_DIV
    } state_t;

    localparam int IW = sdbp_pkg::IDX_W;
    localparam int PW = sdbp_pkg::PROB_BITS;
    localparam int SW = sdbp_pkg::SUM_W;
    localparam int NW = sdbp_pkg::NUM_W;
    localparam int QW = sdbp_pkg::QUO_W;

    state_t state_reg;

    logic [PW-1:0] mem [sdbp_pkg::SYMBOLS];
    logic [sdbp_pkg::SYMBOLS-1:0] valid_reg;
    logic [PW-1:0] mem_q_reg;
    logic          vld_q_reg;
    logic [PW-1:0] rd_val;

    logic [IW-1:0] top_reg, bot_reg, mid_reg;
    logic [IW-1:0] top_next, bot_next, mid_next;
    logic [IW:0]   mid_sum;

    logic [IW-1:0] addr_reg;
    logic          pend_reg;
    logic [IW-1:0] pend_idx_reg;

    logic [SW-1:0] total_reg, upper_reg;
    logic [PW-1:0] best_val_reg;
    logic [IW-1:0] best_idx_reg;

    logic [NW-1:0] num_reg, dsh_reg;
    logic [QW-1:0] quo_reg;
    logic [sdbp_pkg::STEP_W-1:0] step_reg;
    logic          fits;
    logic [QW-1:0] quo_next;

    logic accept, load_go, step_go, load_in_range;

    logic                          result_valid_reg;
    logic [sdbp_pkg::OUT_BITS-1:0] bit_prob_reg;
    logic [7:0]                    likely_symbol_reg;

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign load_in_range = ({1'b0, entry_index} < 9'(sdbp_pkg::SYMBOLS));
    assign load_go       = accept && (cmd == sdbp_pkg::CMD_LOAD) && load_in_range;
    assign step_go       = accept && (cmd == sdbp_pkg::CMD_STEP);

    always_comb
    begin
        bot_next = bot_reg;
        top_next = top_reg;
        if (bit_position == 3'd0)
        begin
            bot_next = '0;
            top_next = sdbp_pkg::TOP_INIT;
        end
        else if (prev_bit)
        begin
            bot_next = (mid_reg < top_reg) ? mid_reg + IW'(1) : top_reg;
        end
        else
        begin
            top_next = mid_reg;
        end
        mid_sum  = {1'b0, bot_next} + {1'b0, top_next};
        mid_next = mid_sum[IW:1];
    end

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            mem[entry_index[IW-1:0]] <= entry_prob[PW-1:0];
        end
        mem_q_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (load_go)
            begin
                valid_reg[entry_index[IW-1:0]] <= 1'b1;
            end
            vld_q_reg <= valid_reg[addr_reg];
        end
    end

    assign rd_val = vld_q_reg ? mem_q_reg : sdbp_pkg::PROB_INIT;

    assign fits     = (num_reg >= dsh_reg);
    assign quo_next = {quo_reg[QW-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            top_reg           <= sdbp_pkg::TOP_INIT;
            bot_reg           <= '0;
            mid_reg           <= '0;
            addr_reg          <= '0;
            pend_reg          <= 1'b0;
            pend_idx_reg      <= '0;
            total_reg         <= '0;
            upper_reg         <= '0;
            best_val_reg      <= '0;
            best_idx_reg      <= '0;
            num_reg           <= '0;
            dsh_reg           <= '0;
            quo_reg           <= '0;
            step_reg          <= '0;
            result_valid_reg  <= 1'b0;
            bit_prob_reg      <= '0;
            likely_symbol_reg <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            pend_reg         <= (state_reg == ST_SCAN);
            pend_idx_reg     <= addr_reg;

            if (pend_reg)
            begin
                total_reg <= total_reg + SW'(rd_val);
                if (pend_idx_reg > mid_reg)
                begin
                    upper_reg <= upper_reg + SW'(rd_val);
                end
                if ((pend_idx_reg == bot_reg) || (rd_val > best_val_reg))
                begin
                    best_val_reg <= rd_val;
                    best_idx_reg <= pend_idx_reg;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (step_go)
                    begin
                        bot_reg   <= bot_next;
                        top_reg   <= top_next;
                        mid_reg   <= mid_next;
                        addr_reg  <= bot_next;
                        total_reg <= '0;
                        upper_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (addr_reg == top_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + IW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    if (total_reg == '0)
                    begin
                        bit_prob_reg      <= sdbp_pkg::P_HALF;
                        likely_symbol_reg <= 8'(best_idx_reg);
                        result_valid_reg  <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        num_reg   <= (NW'(upper_reg) << (sdbp_pkg::OUT_BITS + 1))
                                     + NW'(total_reg);
                        dsh_reg   <= NW'(total_reg) << QW;
                        quo_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (fits)
                    begin
                        num_reg <= num_reg - dsh_reg;
                    end
                    dsh_reg  <= dsh_reg >> 1;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + sdbp_pkg::STEP_W'(1);
                    if (step_reg == sdbp_pkg::STEP_W'(QW - 1))
                    begin
                        if (quo_next == '0)
                        begin
                            bit_prob_reg <= sdbp_pkg::P_MIN;
                        end
                        else if (quo_next[QW-1])
                        begin
                            bit_prob_reg <= sdbp_pkg::P_MAX;
                        end
                        else
                        begin
                            bit_prob_reg <= quo_next[QW-2:0];
                        end
                        likely_symbol_reg <= 8'(best_idx_reg);
                        result_valid_reg  <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = result_valid_reg;
    assign bit_prob      = bit_prob_reg;
    assign likely_symbol = likely_symbol_reg;

`ifndef NO_ASSERTIONS
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (bot_reg <= mid_reg) && (mid_reg <= top_reg))
        else $error("symbol range out of order");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step_go |=> busy)
        else $error("bit step did not raise busy");

    a_prob_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (bit_prob != '0))
        else $error("bit probability not clamped");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (addr_reg >= bot_reg) && (addr_reg <= top_reg))
        else $error("scan address left the range");
`endif

endmodule

// File: tb/symbol_dist_to_bit_prediction_tb.sv
`timescale 1ns / 1ps

module symbol_dist_to_bit_prediction_tb;

    localparam int RANDOM_ITEMS = 1600;
    localparam int MAX_GAP      = 40;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct {
        logic        cmd;
        logic [7:0]  entry_index;
        logic [15:0] entry_prob;
        logic [2:0]  bit_position;
        logic        prev_bit;
        int          gap;
    } command_t;

    typedef struct {
        logic [sdbp_pkg::OUT_BITS-1:0] bit_prob;
        logic [7:0]                    likely_symbol;
    } prediction_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          cmd = 1'b0;
    logic [7:0]                    entry_index = '0;
    logic [15:0]                   entry_prob = '0;
    logic [2:0]                    bit_position = '0;
    logic                          prev_bit = 1'b0;
    logic                          busy;
    logic                          result_valid;
    logic [sdbp_pkg::OUT_BITS-1:0] bit_prob;
    logic [7:0]                    likely_symbol;

    command_t    command_queue[$];
    prediction_t expected_predictions[$];

    logic [sdbp_pkg::PROB_BITS-1:0] sym_prob[sdbp_pkg::SYMBOLS];
    logic [7:0]                     rng_lo;
    logic [7:0]                     rng_hi;
    logic [7:0]                     rng_mid;

    command_t cur;
    logic     holding = 1'b0;
    int       gap_left = 0;
    int       idle_pct = 0;
    int       n_queued = 0;
    int       n_accepted = 0;
    int       n_steps = 0;
    int       n_checked = 0;
    int       n_mismatch = 0;
    int       n_empty_range = 0;
    int       n_clamped = 0;
    int       cycle_count = 0;

    symbol_dist_to_bit_prediction dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .entry_index   (entry_index),
        .entry_prob    (entry_prob),
        .bit_position  (bit_position),
        .prev_bit      (prev_bit),
        .result_valid  (result_valid),
        .bit_prob      (bit_prob),
        .likely_symbol (likely_symbol)
    );

    always #1 clk = ~clk;

    function automatic int draw_gap(input int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    function automatic logic [15:0] draw_prob();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(255));
            3:       return 16'h0001;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic push_load(input logic [7:0] idx, input logic [15:0] val);
        command_t c;
        c.cmd          = sdbp_pkg::CMD_LOAD;
        c.entry_index  = idx;
        c.entry_prob   = val;
        c.bit_position = 3'($urandom);
        c.prev_bit     = 1'($urandom);
        c.gap          = draw_gap(idle_pct);
        command_queue.push_back(c);
        n_queued++;
    endtask

    task automatic push_step(input logic [2:0] pos, input logic b);
        command_t c;
        c.cmd          = sdbp_pkg::CMD_STEP;
        c.entry_index  = 8'($urandom);
        c.entry_prob   = 16'($urandom);
        c.bit_position = pos;
        c.prev_bit     = b;
        c.gap          = draw_gap(idle_pct);
        command_queue.push_back(c);
        n_queued++;
    endtask

    task automatic predict_transaction(input command_t c);
        longint unsigned upper;
        longint unsigned total;
        longint unsigned q;
        logic [7:0]      best;
        logic [15:0]     best_val;
        prediction_t     p;
        upper = 0;
        total = 0;
        if (c.cmd == sdbp_pkg::CMD_LOAD)
        begin
            sym_prob[c.entry_index] = c.entry_prob;
        end
        else
        begin
            if (c.bit_position == 3'd0)
            begin
                rng_lo = '0;
                rng_hi = sdbp_pkg::TOP_INIT;
            end
            else if (c.prev_bit)
                rng_lo = (rng_mid < rng_hi) ? rng_mid + 8'd1 : rng_hi;
            else
                rng_hi = rng_mid;
            rng_mid = 8'((int'(rng_lo) + int'(rng_hi)) / 2);

            best     = rng_lo;
            best_val = sym_prob[rng_lo];
            for (int i = int'(rng_lo); i <= int'(rng_hi); i++)
            begin
                total += sym_prob[i];
                if (i > int'(rng_mid))
                    upper += sym_prob[i];
                if (sym_prob[i] > best_val)
                begin
                    best_val = sym_prob[i];
                    best     = 8'(i);
                end
            end

            if (total == 0)
            begin
                p.bit_prob = sdbp_pkg::P_HALF;
                n_empty_range++;
            end
            else
            begin
                q = (upper * 8192 + total) / (total * 2);
                if (q < 1 || q > 4095)
                    n_clamped++;
                if (q < 1)
                    q = 1;
                if (q > 4095)
                    q = 4095;
                p.bit_prob = sdbp_pkg::OUT_BITS'(q);
            end
            p.likely_symbol = best;
            expected_predictions.push_back(p);
            n_steps++;
        end
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int act_v);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("MISMATCH @%0t %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endtask

    // A transaction is taken at an edge where start is high and busy is low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_transaction(cur);
                n_accepted++;
            end
            if (!start || !busy)
            begin
                if (!holding && command_queue.size() > 0)
                begin
                    cur      = command_queue.pop_front();
                    holding  = 1'b1;
                    gap_left = cur.gap;
                end
                if (holding && gap_left == 0)
                begin
                    start        <= 1'b1;
                    cmd          <= cur.cmd;
                    entry_index  <= cur.entry_index;
                    entry_prob   <= cur.entry_prob;
                    bit_position <= cur.bit_position;
                    prev_bit     <= cur.prev_bit;
                    holding      = 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                    if (holding)
                        gap_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        prediction_t exp_p;
        if (rst_n && result_valid)
        begin
            if (expected_predictions.size() == 0)
            begin
                report_mismatch("unexpected result, bit_prob", -1, int'(bit_prob));
            end
            else
            begin
                exp_p = expected_predictions.pop_front();
                n_checked++;
                if (bit_prob !== exp_p.bit_prob)
                    report_mismatch("bit_prob", int'(exp_p.bit_prob), int'(bit_prob));
                if (likely_symbol !== exp_p.likely_symbol)
                    report_mismatch("likely_symbol", int'(exp_p.likely_symbol),
                                    int'(likely_symbol));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_predictions.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int choice;
        int base;
        int len;
        logic [15:0] run_val;

        for (int i = 0; i < sdbp_pkg::SYMBOLS; i++)
            sym_prob[i] = sdbp_pkg::PROB_INIT;
        rng_lo  = '0;
        rng_hi  = sdbp_pkg::TOP_INIT;
        rng_mid = '0;

        // Directed part: flat table, then extreme entries driving the clamps,
        // an empty range total and a range narrowed down to one symbol.
        idle_pct = 0;
        push_step(3'd0, 1'b1);
        push_load(8'd0, 16'hFFFF);
        push_load(8'd255, 16'h0000);
        push_step(3'd0, 1'b0);
        for (int p = 1; p < 8; p++)
            push_step(3'(p), 1'b1);
        push_step(3'd7, 1'b1);
        push_step(3'd3, 1'b1);
        push_step(3'd5, 1'b0);
        push_load(8'd0, 16'h0001);
        push_load(8'd1, 16'hFFFF);
        push_step(3'd0, 1'b1);
        for (int p = 1; p < 8; p++)
            push_step(3'(p), 1'b0);

        base = n_queued;
        while (n_queued - base < RANDOM_ITEMS)
        begin
            case (((n_queued - base) * 4) / RANDOM_ITEMS)
                0:       idle_pct = 0;
                1:       idle_pct = 58;
                2:       idle_pct = 0;
                default: idle_pct = 28;
            endcase
            choice = $urandom_range(99);
            if (choice < 30)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    push_load(8'($urandom_range(255)), draw_prob());
            end
            else if (choice < 38)
            begin
                len     = $urandom_range(2, 16);
                run_val = ($urandom_range(2) == 0) ? draw_prob() : 16'h0000;
                choice  = $urandom_range(255);
                for (int k = 0; k < len; k++)
                    push_load(8'(choice + k), run_val);
            end
            else if (choice < 88)
            begin
                push_step(3'd0, 1'($urandom));
                for (int p = 1; p < 8; p++)
                    push_step(3'(p), 1'($urandom));
                if ($urandom_range(3) == 0)
                begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++)
                        push_step(3'($urandom_range(1, 7)), 1'($urandom));
                end
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    push_step(3'($urandom_range(7)), 1'($urandom));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_accepted == n_queued);
        @(posedge clk);
        while (expected_predictions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands, %0d of them bit steps; %0d predictions compared.",
                 n_accepted, n_steps, n_checked);
        $display("Zero-total ranges: %0d, clamped probabilities: %0d, mismatches: %0d.",
                 n_empty_range, n_clamped, n_mismatch);
        if (n_mismatch == 0 && expected_predictions.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
